// ===== design/pioenc_pkg.sv =====
// Package for the instruction encoder: payload structs, field constants and opcodes.
// It depends on nothing; every other design file uses it by scoped names.
`timescale 1ns / 1ps

package pioenc_pkg;

    localparam int DEFAULT_PROGRAM_SLOTS = 32;

    localparam int OPCODE_W   = 3;
    localparam int SEL_W      = 3;
    localparam int OPERAND_W  = 5;
    localparam int DS_W       = 5;
    localparam int SSW_W      = 3;
    localparam int WORD_W     = 16;
    localparam int ADDR_W     = 5;
    localparam int OPCODE_LSB = 13;
    localparam int DS_LSB     = 8;

    localparam logic [SSW_W-1:0] SIDE_SET_MAX = 3'd5;

    localparam logic [OPERAND_W-1:0] REL_BIT   = 5'h10;
    localparam logic [OPERAND_W-1:0] IRQ_INDEX = 5'h0F;

    typedef enum logic [OPCODE_W-1:0] {
        OP_JMP  = 3'd0,
        OP_WAIT = 3'd1,
        OP_IN   = 3'd2,
        OP_OUT  = 3'd3,
        OP_PUSH = 3'd4,
        OP_MOV  = 3'd5,
        OP_IRQ  = 3'd6,
        OP_SET  = 3'd7
    } opcode_t;

    localparam logic [SEL_W-1:0] IRQ_MODE_WAIT  = 3'd1;
    localparam logic [SEL_W-1:0] IRQ_MODE_CLEAR = 3'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]  opcode;
        logic [SEL_W-1:0]     variant;
        logic [SEL_W-1:0]     source_sel;
        logic [SEL_W-1:0]     dest_sel;
        logic [OPERAND_W-1:0] small_operand;
        logic                 is_pull;
        logic                 if_flag;
        logic                 blocking;
        logic                 relative;
        logic [DS_W-1:0]      delay_cycles;
        logic [DS_W-1:0]      side_value;
        logic                 last;
    } item_t;

    typedef struct packed {
        logic [WORD_W-1:0] machine_word;
        logic [ADDR_W-1:0] slot_address;
        logic [ADDR_W-1:0] wrap_address;
        logic              overflow;
    } result_t;

endpackage

// ===== design/pioenc_pack.sv =====
// Combinational packing of one instruction into its 16-bit machine word.
// Depends on pioenc_pkg for the item type, opcodes and field constants.
`timescale 1ns / 1ps

module pioenc_pack (
    input  pioenc_pkg::item_t                 item,
    input  logic [pioenc_pkg::SSW_W-1:0]      side_set_width,
    output logic [pioenc_pkg::WORD_W-1:0]     machine_word
);

    logic [pioenc_pkg::SSW_W-1:0] side_bits;
    logic [pioenc_pkg::SSW_W-1:0] delay_len;
    logic [pioenc_pkg::DS_W-1:0]  delay_mask;
    logic [pioenc_pkg::DS_W-1:0]  delay_side;
    logic [7:0]                   args;

    // Side-set takes the high bits of the field; widths above five count as five.
    always_comb begin
        side_bits  = (side_set_width > pioenc_pkg::SIDE_SET_MAX) ?
                     pioenc_pkg::SIDE_SET_MAX : side_set_width;
        delay_len  = pioenc_pkg::SIDE_SET_MAX - side_bits;
        delay_mask = 5'((6'd1 << delay_len) - 6'd1);
        delay_side = 5'(item.side_value << delay_len) | (item.delay_cycles & delay_mask);
    end

    always_comb begin
        unique case (pioenc_pkg::opcode_t'(item.opcode))
            pioenc_pkg::OP_JMP:  args = {item.variant, item.small_operand};
            pioenc_pkg::OP_WAIT: args = {item.variant[0], item.source_sel[1:0],
                                         item.relative ?
                                         (item.small_operand | pioenc_pkg::REL_BIT) :
                                         item.small_operand};
            pioenc_pkg::OP_IN:   args = {item.source_sel, item.small_operand};
            pioenc_pkg::OP_OUT:  args = {item.dest_sel, item.small_operand};
            pioenc_pkg::OP_PUSH: args = {item.is_pull, item.if_flag, item.blocking, 5'd0};
            pioenc_pkg::OP_MOV:  args = {item.dest_sel, item.variant[1:0], item.source_sel};
            pioenc_pkg::OP_IRQ:  args = {1'b0,
                                         item.variant == pioenc_pkg::IRQ_MODE_CLEAR,
                                         item.variant == pioenc_pkg::IRQ_MODE_WAIT,
                                         item.relative,
                                         item.small_operand[3:0] &
                                         pioenc_pkg::IRQ_INDEX[3:0]};
            default:             args = {item.dest_sel, item.small_operand};
        endcase
    end

    assign machine_word = {item.opcode, delay_side, args};

endmodule

// ===== design/pio_instruction_encoder.sv =====
// Instruction encoder: one structured instruction in, one packed word and address out.
// A result passes through the input register, then the result register, before it can
// transfer. Throughput: one per cycle while the consumer takes results (m_ready).
// Reset (aresetn, synchronous, active low) empties both stages, clears the slot
// counter and the overflow mark, and sets the side-set width to zero.
// Depends on pioenc_pkg and pioenc_pack.
`timescale 1ns / 1ps

module pio_instruction_encoder #(
    parameter int PROGRAM_SLOTS = pioenc_pkg::DEFAULT_PROGRAM_SLOTS
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    // Configuration write channel: the side-set width register.
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pioenc_pkg::SSW_W-1:0]  cfg_data,

    // Instruction input channel.
    input  logic                          s_valid,
    output logic                          s_ready,
    input  pioenc_pkg::item_t             s_item,

    // Encoded result channel.
    output logic                          m_valid,
    input  logic                          m_ready,
    output pioenc_pkg::result_t           m_result
);

    // The counter has to hold the slot count itself, one past the last address.
    localparam int CNT_W = $clog2(PROGRAM_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS = CNT_W'(PROGRAM_SLOTS);

    logic [pioenc_pkg::SSW_W-1:0] ssw_reg;

    logic                 in_valid_reg;
    pioenc_pkg::item_t    in_item_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    pioenc_pkg::result_t  out_result_reg;
    pioenc_pkg::result_t  out_result_next;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 ovf_seen_reg;
    logic                 ovf_seen_next;

    logic                 advance;
    logic                 full;
    logic [CNT_W-1:0]     count_after;
    logic [5:0]           count_wide;
    logic [pioenc_pkg::WORD_W-1:0] word;

    // Always writable; user writes must only come while the block idles (unenforced).
    assign cfg_ready = 1'b1;

    // The input stage moves on whenever the result register is empty or being
    // drained, so only a result that the consumer does not take blocks the next input transfer.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    pioenc_pack u_pack (
        .item           (in_item_reg),
        .side_set_width (ssw_reg),
        .machine_word   (word)
    );

    // Slot bookkeeping happens as an item leaves the input stage, so items
    // see the counter strictly in transfer order.
    always_comb begin
        full        = count_reg >= SLOTS;
        count_after = full ? count_reg : count_reg + CNT_W'(1);
        count_wide  = 6'(count_after);

        out_result_next.machine_word = full ? '0 : word;
        out_result_next.slot_address = full ? '0 : pioenc_pkg::ADDR_W'(count_reg);
        out_result_next.overflow     = full || ovf_seen_reg;
        // On the last item the wrap address is the final stored word's address.
        if (in_item_reg.last && count_wide != 6'd0) begin
            out_result_next.wrap_address = pioenc_pkg::ADDR_W'(count_wide - 6'd1);
        end else begin
            out_result_next.wrap_address = '0;
        end

        if (in_item_reg.last) begin
            count_next    = '0;
            ovf_seen_next = 1'b0;
        end else begin
            count_next    = count_after;
            ovf_seen_next = full || ovf_seen_reg;
        end

        out_valid_next = advance || (out_valid_reg && !m_ready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ssw_reg       <= '0;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            count_reg     <= '0;
            ovf_seen_reg  <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                ssw_reg <= cfg_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            out_valid_reg <= out_valid_next;
            if (advance) begin
                count_reg    <= count_next;
                ovf_seen_reg <= ovf_seen_next;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_result_reg <= out_result_next;
        end
    end

    assign m_valid  = out_valid_reg;
    assign m_result = out_result_reg;

endmodule

// ===== design/pioenc_checker.sv =====
// Port-level checker for the instruction encoder, bound to the top level.
// Depends on pioenc_pkg for the result type.
`timescale 1ns / 1ps

module pioenc_checker (
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 s_ready,
    input logic                 m_valid,
    input logic                 m_ready,
    input pioenc_pkg::result_t  m_result
);

    // A result waiting for the consumer holds its payload.
    property p_result_holds;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_result);
    endproperty
    a_result_holds: assert property (p_result_holds)
        else $error("result changed while stalled");

    // A refused word carries neither data nor an address.
    property p_overflow_empty;
        @(posedge aclk) disable iff (!aresetn)
        m_valid && m_result.overflow |->
            m_result.machine_word == '0 && m_result.slot_address == '0;
    endproperty
    a_overflow_empty: assert property (p_overflow_empty)
        else $error("overflow result carries a word or address");

    // With no result pending the input side can never be stalled.
    property p_ready_when_empty;
        @(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready;
    endproperty
    a_ready_when_empty: assert property (p_ready_when_empty)
        else $error("input stalled with empty result register");

    // Reset leaves no result behind.
    property p_reset_empties;
        @(posedge aclk)
        !aresetn |=> !m_valid;
    endproperty
    a_reset_empties: assert property (p_reset_empties)
        else $error("result valid right after reset");

endmodule

bind pio_instruction_encoder pioenc_checker u_pioenc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_result (m_result)
);
